@@ sv/tde_pkg.sv @@
package tde_pkg;

    localparam int NODE_SLOTS = 32;
    localparam int NODE_W     = $clog2(NODE_SLOTS);
    localparam int IDX_W      = NODE_W + 1;
    localparam int CNT_W      = 6;
    localparam int MAX_DISP   = 32;
    localparam logic [7:0] NO_PRIORITY = 8'd255;

    typedef enum logic [2:0] {
        MD_TASK   = 3'd0,
        MD_MAIN   = 3'd1,
        MD_GATE   = 3'd2,
        MD_EXT    = 3'd3,
        MD_EDGE   = 3'd4,
        MD_SUBMIT = 3'd5,
        MD_FINISH = 3'd6,
        MD_SIGNAL = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        RK_CREATED   = 3'd0,
        RK_EDGE      = 3'd1,
        RK_DISPATCH  = 3'd2,
        RK_SUBMITTED = 3'd3,
        RK_CYCLE     = 3'd4,
        RK_FULL      = 3'd5,
        RK_REFUSED   = 3'd6,
        RK_DONE      = 3'd7
    } t_res_kind;

    typedef enum logic [1:0] {
        NK_TASK = 2'd0,
        NK_GATE = 2'd1,
        NK_EXT  = 2'd2
    } t_node_kind;

    typedef enum logic [1:0] {
        TG_MAIN = 2'd0,
        TG_ANY  = 2'd1,
        TG_CPU  = 2'd2,
        TG_PRIO = 2'd3
    } t_target;

    typedef enum logic [1:0] {
        TK_PLAIN = 2'd0,
        TK_FIBER = 2'd1,
        TK_CORO  = 2'd2
    } t_task_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_KAHN,
        ST_SCAN,
        ST_WALK,
        ST_CLOSE
    } t_state;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_EXEC,
        OP_KAHN,
        OP_SCAN,
        OP_WALK,
        OP_CLOSE
    } t_dp_op;

    typedef struct packed {
        logic [2:0] mode;
        logic [4:0] node_a;
        logic [4:0] node_b;
        logic [1:0] task_kind;
        logic [7:0] priority_req;
        logic [7:0] cpu_id;
        logic       gate_or;
    } t_in_word;

    typedef struct packed {
        logic [2:0] kind;
        logic [4:0] node_id;
        logic [1:0] target;
        logic [7:0] target_cpu;
        logic [7:0] task_priority;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic   load;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic rdy;       // output register can take a word
        logic go_idle;   // final word issued
        logic go_kahn;
        logic go_scan;
        logic go_close;
        logic walk_go;   // a walk was started
        logic walk_end;  // walk finished with empty stack
    } t_dp_sts;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [IDX_W-1:0]  idx;
    } t_frame;

    function automatic logic [NODE_W-1:0] f_first(input logic [NODE_SLOTS-1:0] v);
        logic [NODE_W-1:0] r;
        r = '0;
        for (int k = NODE_SLOTS - 1; k >= 0; k--) begin
            if (v[k]) begin
                r = NODE_W'(k);
            end
        end
        return r;
    endfunction

endpackage

@@ sv/tde_ctrl.sv @@
module tde_ctrl
    import tde_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_in_stall
);

    t_state r_state, n_state;
    logic   r_ret_scan, n_ret_scan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_ret_scan <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ret_scan <= n_ret_scan;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_ret_scan = r_ret_scan;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_ret_scan = 1'b0;
                if (i_sts.rdy) begin
                    if (i_sts.go_idle)      n_state = ST_IDLE;
                    else if (i_sts.go_kahn) n_state = ST_KAHN;
                    else if (i_sts.walk_go) n_state = ST_WALK;
                end
            end
            ST_KAHN: begin
                if (i_sts.rdy) begin
                    if (i_sts.go_idle)      n_state = ST_IDLE;
                    else if (i_sts.go_scan) n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_ret_scan = 1'b1;
                if (i_sts.rdy) begin
                    if (i_sts.walk_go)       n_state = ST_WALK;
                    else if (i_sts.go_close) n_state = ST_CLOSE;
                end
            end
            ST_WALK: begin
                if (i_sts.rdy && i_sts.walk_end) begin
                    n_state = r_ret_scan ? ST_SCAN : ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                if (i_sts.rdy) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.load = 1'b0;
        o_cmd.op   = OP_IDLE;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_EXEC:  o_cmd.op = OP_EXEC;
            ST_KAHN:  o_cmd.op = OP_KAHN;
            ST_SCAN:  o_cmd.op = OP_SCAN;
            ST_WALK:  o_cmd.op = OP_WALK;
            ST_CLOSE: o_cmd.op = OP_CLOSE;
            default:  o_cmd.op = OP_IDLE;
        endcase
    end

endmodule

@@ sv/tde_dp.sv @@
module tde_dp
    import tde_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    input  t_in_word  i_in_word,
    input  logic      i_out_stall,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    output t_out_word o_out_word
);

    // node table
    logic [NODE_SLOTS-1:0] r_used, n_used;
    t_node_kind            r_kind [NODE_SLOTS];
    t_node_kind            n_kind [NODE_SLOTS];
    logic [NODE_SLOTS-1:0] r_is_or, n_is_or;
    logic [NODE_SLOTS-1:0] r_main, n_main;
    logic [7:0]            r_prio [NODE_SLOTS];
    logic [7:0]            n_prio [NODE_SLOTS];
    logic [7:0]            r_cpu  [NODE_SLOTS];
    logic [7:0]            n_cpu  [NODE_SLOTS];
    logic [CNT_W-1:0]      r_pend [NODE_SLOTS];
    logic [CNT_W-1:0]      n_pend [NODE_SLOTS];
    logic [NODE_SLOTS-1:0] r_fired, n_fired;
    logic [NODE_SLOTS-1:0] r_armed, n_armed;
    logic [NODE_SLOTS-1:0] r_sig, n_sig;
    logic [NODE_SLOTS-1:0] r_unsub, n_unsub;
    logic [NODE_SLOTS-1:0] r_row  [NODE_SLOTS];
    logic [NODE_SLOTS-1:0] n_row  [NODE_SLOTS];
    logic [CNT_W-1:0]      r_scr  [NODE_SLOTS];
    logic [CNT_W-1:0]      n_scr  [NODE_SLOTS];

    // sequencing
    t_in_word              r_in;
    logic [NODE_SLOTS-1:0] r_kq, n_kq;
    logic [NODE_SLOTS-1:0] r_kdone, n_kdone;
    logic [NODE_SLOTS-1:0] r_fmask, n_fmask;
    logic [NODE_W-1:0]     r_cur_node, n_cur_node;
    logic [IDX_W-1:0]      r_cur_idx, n_cur_idx;
    logic [IDX_W-1:0]      r_sp, n_sp;
    t_frame                r_stk [NODE_SLOTS];
    t_frame                n_stk [NODE_SLOTS];
    t_res_kind             r_close, n_close;
    logic [IDX_W-1:0]      r_disp_cnt, n_disp_cnt;
    logic                  r_out_valid, n_out_valid;
    t_out_word             r_out, n_out;

    logic                  rdy;
    logic                  f_req, f_push;
    logic [NODE_W-1:0]     f_node;
    logic [NODE_SLOTS-1:0] fm;
    logic [NODE_W-1:0]     a, b, n, d, slot;
    logic                  ready;
    t_frame                top;

    assign rdy = !r_out_valid || !i_out_stall;

    always_comb begin
        n_used = r_used; n_kind = r_kind; n_is_or = r_is_or; n_main = r_main;
        n_prio = r_prio; n_cpu = r_cpu; n_pend = r_pend; n_fired = r_fired;
        n_armed = r_armed; n_sig = r_sig; n_unsub = r_unsub; n_row = r_row;
        n_scr = r_scr; n_kq = r_kq; n_kdone = r_kdone; n_fmask = r_fmask;
        n_cur_node = r_cur_node; n_cur_idx = r_cur_idx; n_sp = r_sp;
        n_stk = r_stk; n_close = r_close; n_disp_cnt = r_disp_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out = r_out;
        o_sts = '0;
        o_sts.rdy = rdy;
        f_req = 1'b0; f_push = 1'b0; f_node = '0;
        fm = '0;
        a = r_in.node_a;
        b = r_in.node_b;
        n = r_cur_node;
        d = r_cur_idx[NODE_W-1:0];
        slot = f_first(~r_used);
        ready = 1'b0;
        top = r_stk[NODE_W'(r_sp - IDX_W'(1))];

        if (i_cmd.load) begin
            n_disp_cnt = '0;
        end

        if (rdy) begin
            case (i_cmd.op)
                OP_EXEC: begin
                    n_out = '0;
                    n_out.last = 1'b1;
                    n_out_valid = 1'b1;
                    o_sts.go_idle = 1'b1;
                    case (r_in.mode)
                        MD_TASK, MD_MAIN, MD_GATE, MD_EXT: begin
                            if ((r_in.mode == MD_TASK && r_in.task_kind >= TK_CORO) ||
                                (r_in.mode == MD_MAIN && r_in.task_kind != TK_PLAIN)) begin
                                n_out.kind = RK_REFUSED;
                            end else if (&r_used) begin
                                n_out.kind = RK_FULL;
                            end else begin
                                n_out.kind    = RK_CREATED;
                                n_out.node_id = slot;
                                n_used[slot]  = 1'b1;
                                n_unsub[slot] = 1'b1;
                                n_main[slot]  = (r_in.mode == MD_MAIN);
                                n_is_or[slot] = (r_in.mode == MD_GATE) && r_in.gate_or;
                                n_kind[slot]  = (r_in.mode == MD_GATE) ? NK_GATE :
                                                (r_in.mode == MD_EXT)  ? NK_EXT : NK_TASK;
                                n_prio[slot]  = (r_in.mode == MD_TASK || r_in.mode == MD_MAIN)
                                                ? r_in.priority_req : 8'd0;
                                n_cpu[slot]   = (r_in.mode == MD_TASK) ? r_in.cpu_id :
                                                (r_in.mode == MD_MAIN) ? NO_PRIORITY : 8'd0;
                            end
                        end
                        MD_EDGE: begin
                            if (!r_used[a] || !r_used[b] || r_row[b][a] || (&r_pend[a])) begin
                                n_out.kind = RK_REFUSED;
                            end else begin
                                n_out.kind = RK_EDGE;
                                n_pend[a]  = r_pend[a] + CNT_W'(1);
                                n_row[b][a] = 1'b1;
                            end
                        end
                        MD_SUBMIT: begin
                            n_out_valid   = r_out_valid && i_out_stall;
                            n_out         = r_out;
                            o_sts.go_idle = 1'b0;
                            o_sts.go_kahn = 1'b1;
                            n_kdone = '0;
                            for (int k = 0; k < NODE_SLOTS; k++) begin
                                n_scr[k] = r_pend[k];
                                n_kq[k]  = r_unsub[k] && (r_pend[k] == '0);
                            end
                        end
                        MD_FINISH: begin
                            if (!r_used[a] || r_kind[a] != NK_TASK || !r_fired[a]) begin
                                n_out.kind = RK_REFUSED;
                            end else begin
                                n_out_valid   = r_out_valid && i_out_stall;
                                n_out         = r_out;
                                o_sts.go_idle = 1'b0;
                                o_sts.walk_go = 1'b1;
                                n_close = RK_DONE;
                                n_cur_node = a; n_cur_idx = '0; n_sp = '0;
                            end
                        end
                        default: begin
                            if (!r_used[a] || r_kind[a] != NK_EXT) begin
                                n_out.kind = RK_REFUSED;
                            end else begin
                                n_out.kind = RK_DONE;
                                if (!r_sig[a]) begin
                                    n_sig[a] = 1'b1;
                                    if (r_armed[a]) begin
                                        n_out_valid   = r_out_valid && i_out_stall;
                                        n_out         = r_out;
                                        o_sts.go_idle = 1'b0;
                                        o_sts.walk_go = 1'b1;
                                        n_close = RK_DONE;
                                        n_cur_node = a; n_cur_idx = '0; n_sp = '0;
                                    end
                                end
                            end
                        end
                    endcase
                end
                OP_KAHN: begin
                    if (r_kq != '0) begin
                        n = f_first(r_kq);
                        n_kq[n]    = 1'b0;
                        n_kdone[n] = 1'b1;
                        for (int k = 0; k < NODE_SLOTS; k++) begin
                            if (r_row[n][k] && r_unsub[k] && r_scr[k] != '0) begin
                                n_scr[k] = r_scr[k] - CNT_W'(1);
                                if (r_scr[k] == CNT_W'(1)) n_kq[k] = 1'b1;
                            end
                        end
                    end else if ((r_unsub & ~r_kdone) != '0) begin
                        fm = r_unsub;
                        n_out = '0;
                        n_out.kind = RK_CYCLE;
                        n_out.last = 1'b1;
                        n_out_valid = 1'b1;
                        o_sts.go_idle = 1'b1;
                    end else begin
                        for (int k = 0; k < NODE_SLOTS; k++) begin
                            n_fmask[k] = r_unsub[k] && (r_pend[k] == '0);
                        end
                        n_unsub = '0;
                        n_close = RK_SUBMITTED;
                        o_sts.go_scan = 1'b1;
                    end
                end
                OP_SCAN: begin
                    if (r_fmask == '0) begin
                        o_sts.go_close = 1'b1;
                    end else begin
                        f_node = f_first(r_fmask);
                        n_fmask[f_node] = 1'b0;
                        f_req = 1'b1;
                    end
                end
                OP_WALK: begin
                    if (r_cur_idx[NODE_W]) begin
                        // row done: release the node, resume the parent
                        fm[n] = 1'b1;
                        if (r_sp != '0) begin
                            n_sp = r_sp - IDX_W'(1);
                            n_cur_node = top.node;
                            n_cur_idx  = top.idx;
                        end else begin
                            o_sts.walk_end = 1'b1;
                        end
                    end else begin
                        n_cur_idx = r_cur_idx + IDX_W'(1);
                        if (r_row[n][d] && r_used[d]) begin
                            if (r_kind[d] == NK_GATE && r_is_or[d]) begin
                                ready = 1'b1;
                            end else if (r_pend[d] != '0) begin
                                n_pend[d] = r_pend[d] - CNT_W'(1);
                                ready = (r_pend[d] == CNT_W'(1));
                            end
                        end
                        f_req  = ready;
                        f_push = 1'b1;
                        f_node = d;
                    end
                end
                OP_CLOSE: begin
                    n_out = '0;
                    n_out.kind = r_close;
                    n_out.last = 1'b1;
                    n_out_valid = 1'b1;
                end
                default: ;
            endcase
        end

        // fire one node
        if (f_req && r_used[f_node] && !r_fired[f_node]) begin
            n_fired[f_node] = 1'b1;
            case (r_kind[f_node])
                NK_GATE, NK_EXT: begin
                    if (r_kind[f_node] == NK_EXT) n_armed[f_node] = 1'b1;
                    if (r_kind[f_node] == NK_GATE || r_sig[f_node]) begin
                        if (f_push) begin
                            n_stk[r_sp[NODE_W-1:0]] = '{node: r_cur_node,
                                                         idx: r_cur_idx + IDX_W'(1)};
                            n_sp = r_sp + IDX_W'(1);
                        end
                        n_cur_node = f_node;
                        n_cur_idx  = '0;
                        o_sts.walk_go = 1'b1;
                    end
                end
                NK_TASK: begin
                    if (r_disp_cnt < IDX_W'(MAX_DISP)) begin
                        n_disp_cnt = r_disp_cnt + IDX_W'(1);
                        n_out = '0;
                        n_out.kind = RK_DISPATCH;
                        n_out.node_id = f_node;
                        n_out_valid = 1'b1;
                        if (r_main[f_node]) begin
                            n_out.target = TG_MAIN;
                        end else if (r_prio[f_node] == NO_PRIORITY) begin
                            if (r_cpu[f_node] == 8'd0) begin
                                n_out.target = TG_ANY;
                            end else begin
                                n_out.target     = TG_CPU;
                                n_out.target_cpu = r_cpu[f_node];
                            end
                        end else begin
                            n_out.target        = TG_PRIO;
                            n_out.task_priority = r_prio[f_node];
                        end
                    end
                end
                default: ;
            endcase
        end

        // release nodes: clear their entries and their column in every row
        for (int k = 0; k < NODE_SLOTS; k++) begin
            if (fm[k]) begin
                n_used[k] = 1'b0; n_kind[k] = NK_TASK; n_is_or[k] = 1'b0;
                n_main[k] = 1'b0; n_pend[k] = '0; n_fired[k] = 1'b0;
                n_armed[k] = 1'b0; n_sig[k] = 1'b0; n_unsub[k] = 1'b0;
                n_row[k] = '0;
            end
            n_row[k] = n_row[k] & ~fm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0; r_is_or <= '0; r_main <= '0; r_fired <= '0;
            r_armed <= '0; r_sig <= '0; r_unsub <= '0;
            r_kq <= '0; r_kdone <= '0; r_fmask <= '0;
            r_sp <= '0; r_disp_cnt <= '0; r_out_valid <= 1'b0;
            r_close <= RK_DONE;
            for (int k = 0; k < NODE_SLOTS; k++) begin
                r_kind[k] <= NK_TASK;
                r_pend[k] <= '0;
                r_row[k]  <= '0;
            end
        end else begin
            r_used <= n_used; r_is_or <= n_is_or; r_main <= n_main; r_fired <= n_fired;
            r_armed <= n_armed; r_sig <= n_sig; r_unsub <= n_unsub;
            r_kq <= n_kq; r_kdone <= n_kdone; r_fmask <= n_fmask;
            r_sp <= n_sp; r_disp_cnt <= n_disp_cnt; r_out_valid <= n_out_valid;
            r_close <= n_close;
            r_kind <= n_kind;
            r_pend <= n_pend;
            r_row  <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_cpu  <= n_cpu;
        r_scr  <= n_scr;
        r_stk  <= n_stk;
        r_cur_node <= n_cur_node;
        r_cur_idx  <= n_cur_idx;
        r_out <= n_out;
        if (i_cmd.load) r_in <= i_in_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

@@ sv/task_dependency_engine_unit.sv @@
// Task dependency engine: a 32-node task graph with dependency counters.
// Input channel (i_in_valid / o_in_stall / i_in_word) takes one command word:
//   create task, main task, gate or external node; add an edge; submit;
//   report a task finished; signal an external node.
// Output channel (o_out_valid / i_out_stall / o_out_word) returns zero or more
//   dispatch words followed by one closing word with last set.
// One command is worked on at a time; o_in_stall is high until its closing
//   word has been written into the output register.
// Submit runs a Kahn count-down, one node per cycle while the output is not
//   stalled, with all its dependents updated at once, then scans the roots;
//   a submit that finds a cycle closes with a cycle word after the count-down.
//   Finish and signal walk the dependents row of every completing node one bit
//   per cycle while the output is not stalled. Gates and signalled external
//   nodes fired by submit are walked the same way.
// The output register holds one word; a stall while it holds a word freezes
//   the whole sequencer until the word is taken. A command emits at most 32
//   dispatch words; a task made ready beyond that is marked fired with no word.
// Reset (synchronous, active low) empties the node table at once; the block
//   comes out of reset idle, ready to take a command.
module task_dependency_engine_unit
    import tde_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer: phase of the current command
    tde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // node table, Kahn check, completion walk and output register
    tde_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

@@ sv/tde_checker.sv @@
module tde_checker
    import tde_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    // a taken command keeps the input side busy next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accept");

    // only dispatch words are non-final
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_word.kind == RK_DISPATCH) != o_out_word.last))
        else $error("last flag does not match word kind");

    // non-dispatch words carry no routing
    a_no_route: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.kind != RK_DISPATCH |->
            o_out_word.target == 2'd0 && o_out_word.target_cpu == 8'd0 &&
            o_out_word.task_priority == 8'd0)
        else $error("routing on a closing word");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed under stall");

endmodule

bind task_dependency_engine_unit tde_checker u_tde_checker (.*);
